/* rtl/core/yufmm_pkg.sv */
// ----------------------------------------------------------------------------
// yufmm_pkg : shared types and constants of the heading filter
// fixed field widths, q4.15 angle constants and the sequencer states
// ----------------------------------------------------------------------------
package yufmm_pkg;

  localparam int ID_W        = 6;
  localparam int ANGLE_W     = 20;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // q4.15 constants
  localparam int Q_PI     = 102944;
  localparam int Q_TWO_PI = 205887;
  localparam int FLIP_LO  = 77175;   // pi - (pi/4 + 0.001)
  localparam int FLIP_HI  = 128713;  // pi + (pi/4 + 0.001)
  localparam int ANG_MAX  = 524287;
  localparam int ANG_MIN  = -524288;

  // width of the correction path: differences stay within +-2^21
  localparam int CORR_W = 23;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_MOD,
    ST_META,
    ST_DIFF,
    ST_SUBW,
    ST_ADDW,
    ST_TGT,
    ST_WRAP,
    ST_CTR,
    ST_SAT,
    ST_WRITE,
    ST_RD,
    ST_ACC,
    ST_ABS,
    ST_RND,
    ST_DIV,
    ST_SIGN,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/yufmm_ram.sv */
// ----------------------------------------------------------------------------
// yufmm_ram : generic single-port ram
// one access per cycle, write or read, read data registered
// ----------------------------------------------------------------------------
module yufmm_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 320,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem_r[addr_i] <= wdata_i;
    end
    rdata_r <= mem_r[addr_i];
  end

  assign rdata_o = rdata_r;

endmodule

/* rtl/core/yufmm_alu.sv */
// ----------------------------------------------------------------------------
// yufmm_alu : shared add / subtract unit
// signed sum or difference plus its magnitude
// ----------------------------------------------------------------------------
module yufmm_alu #(
  parameter int DW = 24
) (
  input  logic signed [DW-1:0] a_i,
  input  logic signed [DW-1:0] b_i,
  input  logic                 sub_i,
  output logic signed [DW-1:0] res_o,
  output logic        [DW-1:0] mag_o
);

  always_comb begin
    res_o = sub_i ? (a_i - b_i) : (a_i + b_i);
    mag_o = res_o[DW-1] ? DW'(-res_o) : DW'(res_o);
  end

endmodule

/* rtl/core/yaw_unwrap_flip_moving_mean.sv */
// ----------------------------------------------------------------------------
// yaw_unwrap_flip_moving_mean : heading unwrap, half-turn flip, track mean
// per input word: the held window entries are read and summed, then the mean
//   is divided out at one quotient bit a cycle (24 bits, default parameters);
//   unwrap and wrap steps run before that, except for the first word after reset,
//   and a track id at or above NUM_TRACKS is folded down by NUM_TRACKS per step
// one word in flight at a time; a result waiting in the output
//   register does not hold off the next input word, only the hand-over of its result
// reset (rst_n low, synchronous) clears control state, then a clearing pass
//   over all NUM_TRACKS records zeroes the per-track counts before in_tready rises
// ----------------------------------------------------------------------------
module yaw_unwrap_flip_moving_mean #(
  parameter int NUM_TRACKS = 64,
  parameter int WINDOW_LEN = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input word
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [yufmm_pkg::IN_TDATA_W-1:0]    in_tdata,   // track_id, angle_in, zero pad
  // result word
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [yufmm_pkg::OUT_TDATA_W-1:0]   out_tdata   // filtered_angle, mean_angle
);

  import yufmm_pkg::*;

  // derived widths
  localparam int TW    = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
  localparam int HD    = NUM_TRACKS * WINDOW_LEN;
  localparam int HAW   = (HD > 1) ? $clog2(HD) : 1;
  localparam int CW    = $clog2(WINDOW_LEN + 1);       // window fill count
  localparam int PW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int MW    = CW + PW;                      // per-track record
  localparam int SUM_W = ANGLE_W + CW + 1;
  localparam int ACC_W = (SUM_W > CORR_W) ? SUM_W : CORR_W;
  localparam int BCW   = $clog2(ACC_W + 1);

  localparam logic signed [ACC_W-1:0] K_TWO_PI = ACC_W'(Q_TWO_PI);
  localparam logic signed [ACC_W-1:0] K_PI     = ACC_W'(Q_PI);
  localparam logic signed [ACC_W-1:0] K_MAX    = ACC_W'(ANG_MAX);
  localparam logic signed [ACC_W-1:0] K_MIN    = ACC_W'(ANG_MIN);
  localparam logic        [ACC_W-1:0] K_FLO    = ACC_W'(FLIP_LO);
  localparam logic        [ACC_W-1:0] K_FHI    = ACC_W'(FLIP_HI);

  // sequencer
  state_t state_r, state_nxt;

  // control and datapath registers
  logic [TW-1:0]           clr_cnt_r,  clr_cnt_nxt;
  logic [ID_W-1:0]         id_r,       id_nxt;
  logic [HAW-1:0]          hbase_r,    hbase_nxt;
  logic [CW-1:0]           cnt_r,      cnt_nxt;
  logic [PW-1:0]           ptr_r,      ptr_nxt;
  angle_t                  est_r,      est_nxt;
  angle_t                  last_r,     last_nxt;
  logic                    last_vld_r, last_vld_nxt;
  logic signed [ACC_W-1:0] e_r,        e_nxt;      // candidate minus last heading
  logic        [ACC_W-1:0] base_r,     base_nxt;   // distance without shift
  logic        [ACC_W-1:0] d_r,        d_nxt;      // distance after unwrap
  logic signed [ACC_W-1:0] t_r,        t_nxt;      // unwrapped / wrapped heading
  angle_t                  filt_r,     filt_nxt;
  logic [CW-1:0]           k_r,        k_nxt;
  logic signed [ACC_W-1:0] acc_r,      acc_nxt;    // window sum, then magnitude
  logic                    neg_r,      neg_nxt;
  logic [ACC_W-1:0]        quo_r,      quo_nxt;    // dividend in, quotient out
  logic [CW-1:0]           rem_r,      rem_nxt;
  logic [BCW-1:0]          bit_cnt_r,  bit_cnt_nxt;
  angle_t                  mean_r,     mean_nxt;
  logic                    out_vld_r,  out_vld_nxt;
  angle_t                  out_filt_r, out_filt_nxt;
  angle_t                  out_mean_r, out_mean_nxt;

  // shared unit
  logic signed [ACC_W-1:0] alu_a, alu_b, alu_res;
  logic                    alu_sub;
  logic        [ACC_W-1:0] alu_mag;

  // memories
  logic             meta_we;
  logic [TW-1:0]    meta_addr;
  logic [MW-1:0]    meta_wdata, meta_rdata;
  logic             hist_we;
  logic [HAW-1:0]   hist_addr;
  angle_t           hist_wdata, hist_rdata;

  // helpers
  logic             in_acc;
  logic             out_free;
  logic             id_over;
  logic [CW-1:0]    cnt_inc;
  logic [PW-1:0]    ptr_inc;
  logic [CW-1:0]    k_inc;
  logic [CW:0]      rem_sh;
  logic             flip;

  yufmm_alu #(.DW(ACC_W)) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .mag_o (alu_mag)
  );

  // per-track fill count and write pointer
  yufmm_ram #(.WIDTH(MW), .DEPTH(NUM_TRACKS), .AW(TW)) u_meta_ram (
    .clk     (clk),
    .we_i    (meta_we),
    .addr_i  (meta_addr),
    .wdata_i (meta_wdata),
    .rdata_o (meta_rdata)
  );

  // heading windows, WINDOW_LEN entries per track
  yufmm_ram #(.WIDTH(ANGLE_W), .DEPTH(HD), .AW(HAW)) u_hist_ram (
    .clk     (clk),
    .we_i    (hist_we),
    .addr_i  (hist_addr),
    .wdata_i (hist_wdata),
    .rdata_o (hist_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_mean_r, out_filt_r};

  assign id_over = int'(id_r) >= NUM_TRACKS;
  assign cnt_inc = (cnt_r == CW'(WINDOW_LEN)) ? cnt_r : cnt_r + CW'(1);
  assign ptr_inc = (ptr_r == PW'(WINDOW_LEN - 1)) ? '0 : ptr_r + PW'(1);
  assign k_inc   = k_r + CW'(1);
  assign rem_sh  = {rem_r, quo_r[ACC_W-1]};
  // half-turn flip window, strict on both sides
  assign flip    = (d_r > K_FLO) && (d_r < K_FHI);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        if (clr_cnt_r == TW'(NUM_TRACKS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (!id_over) state_nxt = ST_META;
      end
      ST_META: begin
        state_nxt = last_vld_r ? ST_DIFF : ST_SAT;
      end
      ST_DIFF: state_nxt = ST_SUBW;
      ST_SUBW: begin
        state_nxt = (alu_mag < base_r) ? ST_TGT : ST_ADDW;
      end
      ST_ADDW: state_nxt = ST_TGT;
      ST_TGT: begin
        state_nxt = flip ? ST_WRAP : ST_SAT;
      end
      ST_WRAP: begin
        if (!t_r[ACC_W-1] && (t_r < K_TWO_PI)) state_nxt = ST_CTR;
      end
      ST_CTR:   state_nxt = ST_SAT;
      ST_SAT:   state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_ACC;
      ST_ACC: begin
        state_nxt = (k_inc == cnt_r) ? ST_ABS : ST_RD;
      end
      ST_ABS: state_nxt = ST_RND;
      ST_RND: state_nxt = ST_DIV;
      ST_DIV: begin
        if (bit_cnt_r == BCW'(1)) state_nxt = ST_SIGN;
      end
      ST_SIGN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  // datapath, unit operands and memory control
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    id_nxt       = id_r;
    hbase_nxt    = hbase_r;
    cnt_nxt      = cnt_r;
    ptr_nxt      = ptr_r;
    est_nxt      = est_r;
    last_nxt     = last_r;
    last_vld_nxt = last_vld_r;
    e_nxt        = e_r;
    base_nxt     = base_r;
    d_nxt        = d_r;
    t_nxt        = t_r;
    filt_nxt     = filt_r;
    k_nxt        = k_r;
    acc_nxt      = acc_r;
    neg_nxt      = neg_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    bit_cnt_nxt  = bit_cnt_r;
    mean_nxt     = mean_r;
    out_vld_nxt  = out_vld_r;
    out_filt_nxt = out_filt_r;
    out_mean_nxt = out_mean_r;

    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;

    meta_we    = 1'b0;
    meta_addr  = TW'(id_r);
    meta_wdata = {cnt_inc, ptr_inc};
    hist_we    = 1'b0;
    hist_addr  = hbase_r + HAW'(k_r);
    hist_wdata = filt_r;

    if (out_vld_r && out_tready) out_vld_nxt = 1'b0;

    case (state_r)
      ST_CLR: begin
        meta_we     = 1'b1;
        meta_addr   = clr_cnt_r;
        meta_wdata  = '0;
        clr_cnt_nxt = clr_cnt_r + TW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          id_nxt  = in_tdata[ID_W-1:0];
          est_nxt = in_tdata[ID_W+ANGLE_W-1:ID_W];
        end
      end
      ST_MOD: begin
        // fold an id beyond the table back into range; read its record
        if (id_over) begin
          id_nxt = id_r - ID_W'(NUM_TRACKS);
        end else begin
          hbase_nxt = HAW'(HAW'(TW'(id_r)) * HAW'(WINDOW_LEN));
        end
      end
      ST_META: begin
        cnt_nxt = meta_rdata[MW-1:PW];
        ptr_nxt = meta_rdata[PW-1:0];
        t_nxt   = ACC_W'(est_r);
      end
      ST_DIFF: begin
        alu_a    = ACC_W'(est_r);
        alu_b    = ACC_W'(last_r);
        alu_sub  = 1'b1;
        e_nxt    = alu_res;
        base_nxt = alu_mag;
        d_nxt    = alu_mag;
      end
      ST_SUBW: begin
        // -2*pi wins when strictly nearer
        alu_a   = e_r;
        alu_b   = K_TWO_PI;
        alu_sub = 1'b1;
        if (alu_mag < base_r) begin
          e_nxt = alu_res;
          d_nxt = alu_mag;
        end
      end
      ST_ADDW: begin
        alu_a = e_r;
        alu_b = K_TWO_PI;
        if (alu_mag < base_r) begin
          e_nxt = alu_res;
          d_nxt = alu_mag;
        end
      end
      ST_TGT: begin
        alu_a = ACC_W'(last_r);
        alu_b = e_r;
        t_nxt = alu_res;
      end
      ST_WRAP: begin
        // floor mod 2*pi, one step a cycle
        alu_a = t_r;
        alu_b = K_TWO_PI;
        if (t_r[ACC_W-1]) begin
          t_nxt = alu_res;
        end else if (t_r >= K_TWO_PI) begin
          alu_sub = 1'b1;
          t_nxt   = alu_res;
        end
      end
      ST_CTR: begin
        alu_a   = t_r;
        alu_b   = K_PI;
        alu_sub = 1'b1;
        t_nxt   = alu_res;
      end
      ST_SAT: begin
        if (t_r > K_MAX) begin
          filt_nxt = ANGLE_W'(ANG_MAX);
        end else if (t_r < K_MIN) begin
          filt_nxt = ANGLE_W'(ANG_MIN);
        end else begin
          filt_nxt = ANGLE_W'(t_r);
        end
        last_nxt     = filt_nxt;
        last_vld_nxt = 1'b1;
      end
      ST_WRITE: begin
        hist_we   = 1'b1;
        hist_addr = hbase_r + HAW'(ptr_r);
        meta_we   = 1'b1;
        cnt_nxt   = cnt_inc;
        k_nxt     = '0;
        acc_nxt   = '0;
      end
      ST_RD: begin
        // address set by default from k_r
      end
      ST_ACC: begin
        alu_a   = acc_r;
        alu_b   = ACC_W'(hist_rdata);
        acc_nxt = alu_res;
        k_nxt   = k_inc;
      end
      ST_ABS: begin
        alu_a   = acc_r;
        neg_nxt = acc_r[ACC_W-1];
        acc_nxt = alu_mag;
      end
      ST_RND: begin
        // add half the count, ties round away from zero
        alu_a       = acc_r;
        alu_b       = ACC_W'(cnt_r >> 1);
        quo_nxt     = alu_mag;
        rem_nxt     = '0;
        bit_cnt_nxt = BCW'(ACC_W);
      end
      ST_DIV: begin
        // restoring division, one quotient bit a cycle
        alu_a       = ACC_W'(rem_sh);
        alu_b       = ACC_W'(cnt_r);
        alu_sub     = 1'b1;
        quo_nxt     = {quo_r[ACC_W-2:0], !alu_res[ACC_W-1]};
        rem_nxt     = alu_res[ACC_W-1] ? rem_sh[CW-1:0] : alu_res[CW-1:0];
        bit_cnt_nxt = bit_cnt_r - BCW'(1);
      end
      ST_SIGN: begin
        alu_b    = quo_r;
        alu_sub  = neg_r;
        mean_nxt = ANGLE_W'(alu_res);
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_filt_nxt = filt_r;
          out_mean_nxt = mean_r;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_cnt_r  <= '0;
      last_vld_r <= 1'b0;
      last_r     <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      last_vld_r <= last_vld_nxt;
      last_r     <= last_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    hbase_r    <= hbase_nxt;
    cnt_r      <= cnt_nxt;
    ptr_r      <= ptr_nxt;
    est_r      <= est_nxt;
    e_r        <= e_nxt;
    base_r     <= base_nxt;
    d_r        <= d_nxt;
    t_r        <= t_nxt;
    filt_r     <= filt_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    mean_r     <= mean_nxt;
    out_filt_r <= out_filt_nxt;
    out_mean_r <= out_mean_nxt;
  end

endmodule

/* sim/tb_yaw_unwrap_flip_moving_mean.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yaw_unwrap_flip_moving_mean : self-checking bench of the heading filter
// drives heading words through the input stream and checks every result word
// against an in-bench predictor. The predictor covers unwrap, half-turn flip,
// saturation and the per-track rounded mean. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_yaw_unwrap_flip_moving_mean;
  import yufmm_pkg::*;

  localparam int NUM_TRACKS  = 64;
  localparam int WINDOW_LEN  = 5;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RING_DEPTH  = 8;

  typedef struct packed {
    angle_t filt;
    angle_t mean;
  } heading_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // track_id, angle_in, zero pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // filtered_angle, mean_angle

  // predictor state
  longint heading_last;
  bit     heading_seen;
  longint track_window [NUM_TRACKS][WINDOW_LEN];
  int     track_fill [NUM_TRACKS];
  int     track_slot [NUM_TRACKS];

  // predicted results in flight, written on accept, read on each result word
  heading_result_t result_ring [RING_DEPTH];
  int              ring_wr     = 0;
  int              ring_rd     = 0;
  int              fault_count = 0;
  int              cycle_count = 0;
  int              sink_hold   = 0;
  bit              no_idle     = 1'b0;

  yaw_unwrap_flip_moving_mean #(
    .NUM_TRACKS(NUM_TRACKS),
    .WINDOW_LEN(WINDOW_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic longint clip_angle(longint v);
    if (v > ANG_MAX) return ANG_MAX;
    if (v < ANG_MIN) return ANG_MIN;
    return v;
  endfunction

  function automatic longint abs_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // shift by a full turn when strictly nearer, then flip a near half-turn
  function automatic longint unwrap_heading(longint prev, longint est);
    longint t;
    longint base;
    longint d;
    longint r;
    t    = est;
    base = abs_of(est - prev);
    if (abs_of(est - Q_TWO_PI - prev) < base)
      t = est - Q_TWO_PI;
    else if (abs_of(est + Q_TWO_PI - prev) < base)
      t = est + Q_TWO_PI;
    d = abs_of(prev - t);
    if (d > FLIP_LO && d < FLIP_HI) begin
      // rotate by -pi, wrap into [-pi, pi)
      r = (t - Q_PI + Q_PI) % Q_TWO_PI;
      if (r < 0) r += Q_TWO_PI;
      return r - Q_PI;
    end
    return t;
  endfunction

  function automatic heading_result_t track_heading(logic [ID_W-1:0] id, angle_t ang);
    heading_result_t res;
    longint est;
    longint filt;
    longint sum;
    longint mean;
    int     n;
    int     idx;
    idx  = int'(id) % NUM_TRACKS;
    est  = longint'(ang);
    filt = heading_seen ? clip_angle(unwrap_heading(heading_last, est)) : clip_angle(est);
    heading_last = filt;
    heading_seen = 1'b1;

    track_window[idx][track_slot[idx]] = filt;
    track_slot[idx] = (track_slot[idx] + 1) % WINDOW_LEN;
    if (track_fill[idx] < WINDOW_LEN) track_fill[idx]++;
    n = track_fill[idx];

    sum = 0;
    for (int k = 0; k < n; k++) sum += track_window[idx][k];
    // round to nearest, ties away from zero
    if (sum >= 0) mean = (sum + n / 2) / n;
    else          mean = -((-sum + n / 2) / n);

    res.filt = angle_t'(filt);
    res.mean = angle_t'(clip_angle(mean));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // idling
  // ---------------------------------------------------------------------------
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 25) begin
      sink_hold  <= idle_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // sending
  // ---------------------------------------------------------------------------
  // one heading word; called at a rising edge, returns at the accepting edge
  task automatic push_heading(input logic [ID_W-1:0] id, input angle_t ang);
    if (!no_idle && $urandom_range(0, 99) < 30) begin
      in_tvalid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - ID_W - ANGLE_W){1'b0}}, ang, id};
    do @(posedge clk); while (!in_tready);
    result_ring[ring_wr % RING_DEPTH] = track_heading(id, ang);
    ring_wr++;
  endtask

  // heading placed at an offset from the last filtered heading
  task automatic push_offset(input logic [ID_W-1:0] id, input longint off);
    push_heading(id, angle_t'(clip_angle(heading_last + off)));
  endtask

  // offset pointing back towards zero, keeps the heading inside the range
  task automatic push_toward(input logic [ID_W-1:0] id, input longint m);
    push_offset(id, (heading_last >= 0) ? -m : m);
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : check_results
    heading_result_t want;
    angle_t          got_filt;
    angle_t          got_mean;
    if (rst_n && out_tvalid && out_tready) begin
      got_filt = out_tdata[ANGLE_W-1:0];
      got_mean = out_tdata[2*ANGLE_W-1:ANGLE_W];
      if (ring_wr == ring_rd) begin
        note_fault($sformatf("result word with none pending: filt %0d mean %0d",
                             got_filt, got_mean));
      end else begin
        want = result_ring[ring_rd % RING_DEPTH];
        ring_rd++;
        if (got_filt !== want.filt)
          note_fault($sformatf("filtered_angle expected %0d got %0d", want.filt, got_filt));
        if (got_mean !== want.mean)
          note_fault($sformatf("mean_angle expected %0d got %0d", want.mean, got_mean));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_yaw_unwrap_flip_moving_mean: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // first heading after reset passes unchanged, top of the range
  task automatic test_first_heading();
    push_heading(6'd63, angle_t'(ANG_MAX));
  endtask

  // full-turn shift running off either end of the range
  task automatic test_saturation();
    push_heading(6'd1, angle_t'(390000));   // +2pi overshoots the top
    push_heading(6'd1, angle_t'(ANG_MIN));  // pulled back by +2pi
    push_offset(6'd1, -70000);
    push_offset(6'd1, -70000);
    push_heading(6'd1, angle_t'(ANG_MIN));
    push_heading(6'd1, angle_t'(-390000));  // -2pi undershoots the bottom
  endtask

  // distances on and next to the flip window edges, and near a half and a full turn
  task automatic test_flip_window();
    push_toward(6'd2, FLIP_LO);
    push_toward(6'd2, FLIP_LO + 1);
    push_toward(6'd2, FLIP_HI - 1);
    push_toward(6'd2, FLIP_HI);
    push_toward(6'd2, Q_PI);
    push_toward(6'd2, Q_TWO_PI);
    push_toward(6'd2, Q_PI - 1);
  endtask

  // window fills, wraps, and rounds halves away from zero
  task automatic test_window_wrap();
    push_offset(6'd9, 1);
    push_offset(6'd9, 1);
    push_offset(6'd9, -3);
    push_offset(6'd9, 2);
    push_offset(6'd9, 1);
    push_offset(6'd9, 1);
  endtask

  task automatic test_track_extremes();
    push_offset(6'd0, 5);
    push_offset(6'd63, -5);
  endtask

  // plausible heading streams: jitter, flips, turn wraps, ramps to the ends
  task automatic test_heading_walk(input int count);
    logic [ID_W-1:0] pool [4];
    logic [ID_W-1:0] id;
    bit              climbing;
    bit              ramp_up;
    int              kind;
    int              edges [8];
    longint          m;
    edges = '{FLIP_LO - 1, FLIP_LO, FLIP_LO + 1, FLIP_LO + 2,
              FLIP_HI - 2, FLIP_HI - 1, FLIP_HI, FLIP_HI + 1};
    foreach (pool[i]) pool[i] = ID_W'($urandom_range(0, NUM_TRACKS - 1));
    climbing = 1'b0;
    ramp_up  = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        climbing = ($urandom_range(0, 9) < 3);
        no_idle  <= ($urandom_range(0, 3) == 0);
      end
      id   = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 3)]
                                         : ID_W'($urandom_range(0, NUM_TRACKS - 1));
      kind = $urandom_range(0, 99);
      if (climbing) kind = (kind < 75) ? 80 : 95;
      if (kind < 50) begin
        m = $urandom_range(0, 3000);
        push_offset(id, $urandom_range(0, 1) ? m : -m);
      end else if (kind < 62) begin
        m = Q_PI + longint'($urandom_range(0, 40000)) - 20000;
        push_offset(id, $urandom_range(0, 1) ? m : -m);
      end else if (kind < 70) begin
        m = edges[$urandom_range(0, 7)];
        push_offset(id, $urandom_range(0, 1) ? m : -m);
      end else if (kind < 78) begin
        m = Q_TWO_PI + longint'($urandom_range(0, 4000)) - 2000;
        push_offset(id, $urandom_range(0, 1) ? m : -m);
      end else if (kind < 92) begin
        if ($urandom_range(0, 19) == 0) ramp_up = !ramp_up;
        m = $urandom_range(40000, 75000);
        push_offset(id, ramp_up ? m : -m);
      end else begin
        // step back past the upper flip edge: near an end this saturates
        push_toward(id, $urandom_range(FLIP_HI + 1, 140000));
      end
    end
    no_idle <= 1'b0;
  endtask

  // any track, any angle
  task automatic test_random_words(input int count);
    for (int i = 0; i < count; i++)
      push_heading(ID_W'($urandom_range(0, NUM_TRACKS - 1)), angle_t'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_first_heading();
    test_saturation();
    test_flip_window();
    test_window_wrap();
    test_track_extremes();
    test_heading_walk(700);
    test_random_words(300);

    in_tvalid <= 1'b0;
    while (ring_wr != ring_rd) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fault_count == 0)
      $display("tb_yaw_unwrap_flip_moving_mean: clean");
    else
      $display("tb_yaw_unwrap_flip_moving_mean: errors");
    $finish;
  end

endmodule
